### hw/rtl/sum8fr_pkg.sv
// Package for the SUM8 frame receiver: parse phases, result codes and register indexes.
`default_nettype none
package sum8fr_pkg;

  // Largest PID index accepted by a read request
  localparam logic [7:0] PID_ID_MAX = 8'd9;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_CODE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_CODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_MIN_LEN = 3'd4;

  // Register reset values
  localparam logic [7:0] HEADER_FIRST_RST  = 8'd170;
  localparam logic [7:0] HEADER_SECOND_RST = 8'd255;
  localparam logic [7:0] READ_CODE_RST     = 8'd0;
  localparam logic [7:0] WRITE_CODE_RST    = 8'd1;
  localparam logic [7:0] WRITE_MIN_LEN_RST = 8'd13;

  typedef enum logic [2:0] {
    PH_HUNT1,
    PH_HUNT2,
    PH_CODE,
    PH_LEN,
    PH_DATA,
    PH_SUM
  } phase_t;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_GOOD,
    KIND_BAD
  } kind_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_READ,
    CMD_WRITE
  } cmd_t;

endpackage
`default_nettype wire

### hw/rtl/sum8_frame_receiver_core.sv
// Byte-serial header/length/SUM8 frame receiver, one byte per cycle.
// Latency: a result is valid the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; the single output register refills in the
// same cycle it is taken, so input stalls only while a result waits unread.
// Reset (rst, synchronous): parser hunts the first header byte, counters and
// sum clear, registers return to their defaults, no result pending.
`default_nettype none
module sum8_frame_receiver_core
  import sum8fr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // byte request channel
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [7:0]           rx_byte,
  // result request channel
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                item_kind,
  output logic [7:0]                frame_code,
  output logic [7:0]                byte_index,
  output logic [7:0]                payload_byte,
  output logic [1:0]                command,
  output logic                      frame_last,
  // configuration write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  // Configuration registers
  logic [7:0] header_first;
  logic [7:0] header_second;
  logic [7:0] read_request_code;
  logic [7:0] write_request_code;
  logic [7:0] write_min_length;

  // Parser state
  phase_t     phase, phase_next;
  logic [7:0] code_held, code_held_next;
  logic [7:0] length_held, length_held_next;
  logic [7:0] bytes_seen, bytes_seen_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] first_payload, first_payload_next;

  // Result built from the current byte
  logic       has_result;
  kind_t      kind_new;
  logic [7:0] index_new;
  logic [7:0] value_new;
  cmd_t       cmd_new;
  logic       last_new;

  logic       in_fire;
  logic [7:0] seen_inc;
  logic [7:0] sum_add;
  logic       sum_good;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign seen_inc  = bytes_seen + 8'd1;
  assign sum_add   = running_sum + rx_byte;
  assign sum_good  = (rx_byte == running_sum);

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      header_first       <= HEADER_FIRST_RST;
      header_second      <= HEADER_SECOND_RST;
      read_request_code  <= READ_CODE_RST;
      write_request_code <= WRITE_CODE_RST;
      write_min_length   <= WRITE_MIN_LEN_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HEADER_FIRST:  header_first       <= cfg_data;
        CFG_HEADER_SECOND: header_second      <= cfg_data;
        CFG_READ_CODE:     read_request_code  <= cfg_data;
        CFG_WRITE_CODE:    write_request_code <= cfg_data;
        CFG_WRITE_MIN_LEN: write_min_length   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next parse phase
  always_comb begin
    phase_next = PH_HUNT1;
    unique case (phase)
      PH_HUNT2: begin
        if (rx_byte == header_second) begin
          phase_next = PH_CODE;
        end else if (rx_byte == header_first) begin
          phase_next = PH_HUNT2;
        end else begin
          phase_next = PH_HUNT1;
        end
      end
      PH_CODE: phase_next = PH_LEN;
      PH_LEN:  phase_next = (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
      PH_DATA: phase_next = (seen_inc == length_held) ? PH_SUM : PH_DATA;
      PH_SUM:  phase_next = PH_HUNT1;
      default: phase_next = (rx_byte == header_first) ? PH_HUNT2 : PH_HUNT1;
    endcase
  end

  // Frame fields, sum and result for the current byte
  always_comb begin
    code_held_next     = code_held;
    length_held_next   = length_held;
    bytes_seen_next    = bytes_seen;
    running_sum_next   = running_sum;
    first_payload_next = first_payload;
    has_result         = 1'b0;
    kind_new           = KIND_DATA;
    index_new          = bytes_seen;
    value_new          = rx_byte;
    cmd_new            = CMD_NONE;
    last_new           = 1'b0;
    unique case (phase)
      PH_CODE: begin
        code_held_next   = rx_byte;
        running_sum_next = rx_byte;
      end
      PH_LEN: begin
        length_held_next   = rx_byte;
        running_sum_next   = sum_add;
        bytes_seen_next    = 8'd0;
        first_payload_next = 8'd0;
      end
      PH_DATA: begin
        has_result       = 1'b1;
        running_sum_next = sum_add;
        bytes_seen_next  = seen_inc;
        if (bytes_seen == 8'd0) begin
          first_payload_next = rx_byte;
        end
      end
      PH_SUM: begin
        has_result = 1'b1;
        kind_new   = sum_good ? KIND_GOOD : KIND_BAD;
        index_new  = length_held;
        value_new  = first_payload;
        last_new   = 1'b1;
        // Read is tried first when both codes match
        if (sum_good) begin
          if (code_held == read_request_code) begin
            if (length_held != 8'd0 && first_payload <= PID_ID_MAX) begin
              cmd_new = CMD_READ;
            end
          end else if (code_held == write_request_code) begin
            if (length_held >= write_min_length) begin
              cmd_new = CMD_WRITE;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Advance parser state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT1;
      code_held     <= 8'd0;
      length_held   <= 8'd0;
      bytes_seen    <= 8'd0;
      running_sum   <= 8'd0;
      first_payload <= 8'd0;
    end else if (in_fire) begin
      phase         <= phase_next;
      code_held     <= code_held_next;
      length_held   <= length_held_next;
      bytes_seen    <= bytes_seen_next;
      running_sum   <= running_sum_next;
      first_payload <= first_payload_next;
    end
  end

  // Output register: load a new result, drop a taken one
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= has_result;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Hold result payload
  always_ff @(posedge clk) begin
    if (in_fire && has_result) begin
      item_kind    <= kind_new;
      frame_code   <= code_held;
      byte_index   <= index_new;
      payload_byte <= value_new;
      command      <= cmd_new;
      frame_last   <= last_new;
    end
  end

  // A frame end result and only it is marked last
  a_last_matches_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (frame_last == (item_kind != KIND_DATA)))
    else $error("frame_last disagrees with item_kind");

  // A command is reported only on a good frame end
  a_cmd_only_good: assert property (@(posedge clk) disable iff (rst)
    (out_valid && command != CMD_NONE) |-> (item_kind == KIND_GOOD))
    else $error("command on a result that is not a good frame end");

  // A payload byte always produces a result next cycle
  a_data_emits: assert property (@(posedge clk) disable iff (rst)
    (in_fire && phase == PH_DATA) |=> out_valid)
    else $error("payload byte produced no result");

  // A byte outside payload and checksum leaves no result pending
  a_silent_bytes: assert property (@(posedge clk) disable iff (rst)
    (in_fire && phase != PH_DATA && phase != PH_SUM) |=> !out_valid)
    else $error("unexpected result from a header, code or length byte");

  // The checksum byte is expected only after the full payload
  a_sum_after_payload: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SUM) |-> (bytes_seen == length_held))
    else $error("checksum phase before payload complete");

endmodule
`default_nettype wire
